// ===== src/nss_pkg.sv =====
package nss_pkg;

    localparam int REG_W = 17;
    localparam int SYM_W = 4;
    localparam int STN_W = 3;
    localparam int TAP_SHIFT = 3;

    typedef logic [REG_W-1:0] lfsr_t;

    typedef enum logic [1:0] {
        CMD_INIT       = 2'd0,
        CMD_RESET      = 2'd1,
        CMD_SCRAMBLE   = 2'd2,
        CMD_DESCRAMBLE = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             command;
        logic [STN_W-1:0] station;
        logic [SYM_W-1:0] symbol_in;
        lfsr_t            seed;
        logic             station_in_reset;
    } nss_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic             accepted;
    } nss_out_t;

    // per-station stored record, ready flag lives in flops next to it
    typedef struct packed {
        lfsr_t scr;
        lfsr_t dsc;
        lfsr_t seed;
    } nss_state_t;

    typedef struct packed {
        logic       wr_en;
        nss_state_t state;
        nss_out_t   result;
    } nss_upd_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        lfsr_t            lfsr;
    } nss_run_t;

    // x^17 + x^14 + 1, bit 0 first; feed_out selects scrambler feedback
    function automatic nss_run_t run_symbol(lfsr_t r_in, logic [SYM_W-1:0] sym,
                                            logic feed_out);
        lfsr_t    r;
        logic     din;
        logic     dout;
        logic     fed;
        nss_run_t res;
        r       = r_in;
        res.sym = '0;
        for (int k = 0; k < SYM_W; k++)
        begin
            din        = sym[k];
            dout       = din ^ r[0] ^ r[TAP_SHIFT];
            fed        = feed_out ? dout : din;
            res.sym[k] = dout;
            r          = {fed, r[REG_W-1:1]};
        end
        res.lfsr = r;
        return res;
    endfunction

endpackage

// ===== src/nss_stream_if.sv =====
interface nss_stream_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== src/nss_core.sv =====
module nss_core import nss_pkg::*;
(
    input  cmd_t             command,
    input  logic [SYM_W-1:0] symbol,
    input  lfsr_t            seed,
    input  logic             held,
    input  logic             in_range,
    input  logic             ready_bit,
    input  nss_state_t       state,
    output nss_upd_t         upd
);

    nss_run_t scr_run;
    nss_run_t dsc_run;

    assign scr_run = run_symbol(state.scr, symbol, 1'b1);
    assign dsc_run = run_symbol(state.dsc, symbol, 1'b0);

    always_comb
    begin
        upd.wr_en  = 1'b0;
        upd.state  = state;
        upd.result = '0;
        case (command)
            CMD_INIT:
            begin
                if (in_range)
                begin
                    upd.wr_en           = 1'b1;
                    upd.state.seed      = seed;
                    upd.state.scr       = '0;
                    upd.state.dsc       = '0;
                    upd.result.accepted = 1'b1;
                end
            end
            CMD_RESET:
            begin
                if (in_range && ready_bit)
                begin
                    upd.wr_en           = 1'b1;
                    upd.state.scr       = state.seed;
                    upd.state.dsc       = '0;
                    upd.result.accepted = 1'b1;
                end
            end
            CMD_SCRAMBLE:
            begin
                if (in_range && ready_bit && !held)
                begin
                    upd.wr_en             = 1'b1;
                    upd.state.scr         = scr_run.lfsr;
                    upd.result.symbol_out = scr_run.sym;
                    upd.result.accepted   = 1'b1;
                end
            end
            CMD_DESCRAMBLE:
            begin
                if (in_range && ready_bit && !held)
                begin
                    upd.wr_en             = 1'b1;
                    upd.state.dsc         = dsc_run.lfsr;
                    upd.result.symbol_out = dsc_run.sym;
                    upd.result.accepted   = 1'b1;
                end
            end
            default:
            begin
                upd.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/nibble_self_sync_scrambler.sv =====
// Per-station self-synchronizing scrambler/descrambler (x^17 + x^14 + 1) on 4-bit symbols,
// bit 0 first. One transaction is taken every cycle unless a transaction waits on a stalled full
// output register. The station record is read from a memory with a registered read port, then the
// update runs between that read register and the output register, and the new record is written
// back as the result is registered. Back-to-back transactions to the same station are served by
// a bypass of the record being written. The output register lets a new transaction enter while a
// result still waits. Init, reset and refused commands return symbol_out 0.
module nibble_self_sync_scrambler import nss_pkg::*;
#(
    parameter int STATIONS = 8
)
(
    input logic          clk,
    input logic          rst_n,
    nss_stream_if.sink   in_ch,
    nss_stream_if.source out_ch
);

    localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

    nss_state_t          mem [STATIONS];
    logic [STATIONS-1:0] ready_reg;

    logic                s1_valid_reg;
    nss_in_t             s1_item_reg;
    nss_state_t          rd_reg;
    logic                byp_reg;
    nss_state_t          byp_data_reg;
    logic                out_valid_reg;
    nss_out_t            out_item_reg;

    logic                in_fire;
    logic                s1_adv;
    logic [IDX_W-1:0]    in_addr;
    logic [IDX_W-1:0]    s1_addr;
    logic                s1_in_range;
    nss_state_t          cur_state;
    nss_upd_t            upd;
    logic                mem_wr;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;

    assign in_addr     = IDX_W'(in_ch.payload.station);
    assign s1_addr     = IDX_W'(s1_item_reg.station);
    assign s1_in_range = int'(s1_item_reg.station) < STATIONS;
    assign cur_state   = byp_reg ? byp_data_reg : rd_reg;
    assign mem_wr      = s1_adv && upd.wr_en;

    nss_core u_core (
        .command   (s1_item_reg.command),
        .symbol    (s1_item_reg.symbol_in),
        .seed      (s1_item_reg.seed),
        .held      (s1_item_reg.station_in_reset),
        .in_range  (s1_in_range),
        .ready_bit (s1_in_range && ready_reg[s1_addr]),
        .state     (cur_state),
        .upd       (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ready_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (mem_wr && s1_item_reg.command == CMD_INIT)
            begin
                ready_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // station record memory, registered read with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[s1_addr] <= upd.state;
        end
        if (in_fire)
        begin
            rd_reg       <= mem[in_addr];
            byp_reg      <= mem_wr && (s1_addr == in_addr);
            byp_data_reg <= upd.state;
            s1_item_reg  <= in_ch.payload;
        end
        if (s1_adv)
        begin
            out_item_reg <= upd.result;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

endmodule

// ===== src/nss_checker.sv =====
module nss_checker import nss_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input nss_out_t out_item
);

    // a refused transaction never carries symbol data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.accepted |-> out_item.symbol_out == '0)
        else $error("refused transaction with nonzero symbol");

    // input only backs up when the output register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

endmodule

bind nibble_self_sync_scrambler nss_checker u_nss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
);
